@@ rtl/core/mhdt_pkg.sv @@
// Shared types and constants of the minimum Hamming distance tracker.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
`default_nettype none

package mhdt_pkg;

    // Field widths of the request and result items.
    localparam int VALUE_W  = 64;
    localparam int ENTRY_W  = 6;
    localparam int DIST_W   = 6;
    localparam int CMD_W    = 2;
    localparam int ACTIVE_W = 7;
    localparam int THR_W    = 6;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;

    // The upper bit of each two-bit symbol.
    localparam logic [VALUE_W-1:0] MATCH_BITS = 64'hAAAA_AAAA_AAAA_AAAA;

    // Register indexes, selected by paddr[2].
    localparam logic REG_ACTIVE = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    // Register reset values.
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;
    localparam logic [THR_W-1:0]    THRESH_RESET = 6'd9;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_SCAN    = 2'd1,
        CMD_READ    = 2'd2,
        CMD_SUMMARY = 2'd3
    } cmd_t;

    // One classified request as it waits in the queue.
    typedef struct packed {
        cmd_t                 cmd;
        logic [VALUE_W-1:0]   value;
        logic [ENTRY_W-1:0]   entry;
        logic                 entry_ok;
    } cmd_item_t;

    typedef struct packed {
        logic [ACTIVE_W-1:0] active_entries;
        logic [THR_W-1:0]    far_threshold;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [ENTRY_W-1:0] best_entry;
        logic               far_enough;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

@@ rtl/core/mhdt_front.sv @@
// Front end: accepts requests from the input stream and classifies them.
// Depends on mhdt_pkg; feeds mhdt_queue.
`default_nettype none

module mhdt_front
    import mhdt_pkg::*;
#(
    parameter int ENTRIES = 64
)
(
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [CMD_W-1:0]     s_axis_tuser,
    input  wire logic                 clearing,
    input  wire queue_status_t        q_status,
    output logic                      push,
    output cmd_item_t                 item
);

    localparam logic [31:0] ENTRIES_U = 32'(ENTRIES);

    // No request is taken while the distance store is being cleared.
    assign s_axis_tready = !clearing && !q_status.full;
    assign push          = s_axis_tvalid && s_axis_tready;

    // Split the payload and flag entry indexes that lie outside the table.
    always_comb
    begin
        item.cmd      = cmd_t'(s_axis_tuser);
        item.value    = s_axis_tdata[VALUE_W-1:0];
        item.entry    = s_axis_tdata[VALUE_W+ENTRY_W-1:VALUE_W];
        item.entry_ok = (32'(s_axis_tdata[VALUE_W+ENTRY_W-1:VALUE_W]) < ENTRIES_U);
    end

endmodule

`default_nettype wire

@@ rtl/core/mhdt_queue.sv @@
// Short request queue between the front end and the back end.
// Depends on mhdt_pkg.
`default_nettype none

module mhdt_queue
    import mhdt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire cmd_item_t item_in,
    input  wire logic      pop,
    output cmd_item_t      head,
    output queue_status_t  status
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

@@ rtl/core/mhdt_back.sv @@
// Back end: template and distance memories and the sequencer that runs
// load, scan, read and summary requests. Depends on mhdt_pkg.
`default_nettype none

module mhdt_back
    import mhdt_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int SYMBOLS = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire queue_status_t q_status,
    input  wire cmd_item_t     head,
    output logic               pop,
    output logic               clearing,
    output logic               m_valid,
    input  wire logic          m_ready,
    output result_t            m_result
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int NW    = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

    localparam logic [DIST_W-1:0]  INIT_DIST = DIST_W'(SYMBOLS + 1);
    localparam logic [DIST_W-1:0]  SYM_DIST  = DIST_W'(SYMBOLS);
    localparam logic [CNT_W-1:0]   LAST_IDX  = CNT_W'(ENTRIES - 1);
    localparam logic [VALUE_W-1:0] SYM_MASK  =
        (SYMBOLS >= 32) ? {VALUE_W{1'b1}} : ((64'd1 << (2 * SYMBOLS)) - 64'd1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SUM,
        ST_READ
    } state_t;

    // Number of mismatching symbols between a gram and a template.
    function automatic logic [DIST_W-1:0] sym_distance(
        input logic [VALUE_W-1:0] gram,
        input logic [VALUE_W-1:0] tmpl
    );
        logic [VALUE_W-1:0] same;
        logic [DIST_W-1:0]  hits;
        same = ~(gram ^ tmpl);
        same = same & (same << 1) & MATCH_BITS & SYM_MASK;
        hits = '0;
        for (int k = 0; k < 32; k++)
        begin
            hits = hits + DIST_W'(same[2 * k + 1]);
        end
        return SYM_DIST - hits;
    endfunction

    // Memories.
    logic [VALUE_W-1:0] tmpl_mem_reg [ENTRIES];
    logic [DIST_W-1:0]  min_mem_reg  [ENTRIES];
    logic [VALUE_W-1:0] tmpl_rd_reg;
    logic [DIST_W-1:0]  min_rd_reg;

    logic               tmpl_we;
    logic               min_we;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [DIST_W-1:0]  min_wr_data;

    // Sequencer registers.
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic               pipe_v_reg, pipe_v_next;
    logic [IDX_W-1:0]   pipe_addr_reg, pipe_addr_next;
    logic [VALUE_W-1:0] gram_reg, gram_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [ENTRY_W-1:0] rd_entry_reg, rd_entry_next;
    logic [DIST_W-1:0]  best_val_reg, best_val_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    logic [NW-1:0]      act_wide;
    logic [NW-1:0]      act_n;
    logic [CNT_W-1:0]   n_count;
    logic [DIST_W-1:0]  scan_dist;
    logic               needs_out;
    logic               out_free;

    // Clamp the active entry count to the table size, at least one.
    always_comb
    begin
        act_wide = NW'(cfg.active_entries);
        if (act_wide == '0)
        begin
            act_n = NW'(1);
        end
        else if (act_wide > NW'(ENTRIES))
        begin
            act_n = NW'(ENTRIES);
        end
        else
        begin
            act_n = act_wide;
        end
        n_count = CNT_W'(act_n);
    end

    assign scan_dist = sym_distance(gram_reg, tmpl_rd_reg);
    assign needs_out = (head.cmd == CMD_READ) || (head.cmd == CMD_SUMMARY);
    assign out_free  = !res_valid_reg || m_ready;

    // Sequencer next state, memory port control and result forming.
    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        pipe_v_next    = 1'b0;
        pipe_addr_next = pipe_addr_reg;
        gram_next      = gram_reg;
        rd_ok_next     = rd_ok_reg;
        rd_entry_next  = rd_entry_reg;
        best_val_next  = best_val_reg;
        best_idx_next  = best_idx_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        pop            = 1'b0;
        tmpl_we        = 1'b0;
        min_we         = 1'b0;
        wr_addr        = issue_cnt_reg[IDX_W-1:0];
        rd_addr        = issue_cnt_reg[IDX_W-1:0];
        min_wr_data    = INIT_DIST;

        // The taken result frees the output register.
        if (res_valid_reg && m_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // One entry of the distance store per cycle after reset.
                min_we         = 1'b1;
                issue_cnt_next = issue_cnt_reg + 1'b1;
                if (issue_cnt_reg == LAST_IDX)
                begin
                    issue_cnt_next = '0;
                    state_next     = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (!q_status.empty && (!needs_out || out_free))
                begin
                    pop = 1'b1;
                    case (head.cmd)
                        CMD_LOAD:
                        begin
                            if (head.entry_ok)
                            begin
                                tmpl_we = 1'b1;
                                min_we  = 1'b1;
                                wr_addr = IDX_W'(head.entry);
                            end
                        end
                        CMD_SCAN:
                        begin
                            gram_next      = head.value;
                            issue_cnt_next = '0;
                            state_next     = ST_SCAN;
                        end
                        CMD_READ:
                        begin
                            rd_addr       = IDX_W'(head.entry);
                            rd_ok_next    = head.entry_ok;
                            rd_entry_next = head.entry;
                            state_next    = ST_READ;
                        end
                        CMD_SUMMARY:
                        begin
                            issue_cnt_next = '0;
                            best_val_next  = '0;
                            best_idx_next  = '0;
                            state_next     = ST_SUM;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue one read per cycle; lower the minimum in the cycle after its read.
                if (issue_cnt_reg != n_count)
                begin
                    pipe_v_next    = 1'b1;
                    pipe_addr_next = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                else if (!pipe_v_reg)
                begin
                    state_next = ST_IDLE;
                end
                if (pipe_v_reg && (scan_dist < min_rd_reg))
                begin
                    min_we      = 1'b1;
                    wr_addr     = pipe_addr_reg;
                    min_wr_data = scan_dist;
                end
            end

            ST_SUM:
            begin
                // Walk the active entries keeping the first largest minimum.
                if (issue_cnt_reg != n_count)
                begin
                    pipe_v_next    = 1'b1;
                    pipe_addr_next = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                else if (!pipe_v_reg)
                begin
                    res_valid_next      = 1'b1;
                    res_next.distance   = best_val_reg;
                    res_next.best_entry = ENTRY_W'(best_idx_reg);
                    res_next.far_enough = (best_val_reg >= cfg.far_threshold);
                    state_next          = ST_IDLE;
                end
                if (pipe_v_reg && ((pipe_addr_reg == '0) || (min_rd_reg > best_val_reg)))
                begin
                    best_val_next = min_rd_reg;
                    best_idx_next = pipe_addr_reg;
                end
            end

            ST_READ:
            begin
                res_valid_next      = 1'b1;
                res_next.distance   = rd_ok_reg ? min_rd_reg : '0;
                res_next.best_entry = rd_entry_reg;
                res_next.far_enough = rd_ok_reg && (min_rd_reg >= cfg.far_threshold);
                state_next          = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            issue_cnt_reg <= '0;
            pipe_v_reg    <= 1'b0;
            pipe_addr_reg <= '0;
            gram_reg      <= '0;
            rd_ok_reg     <= 1'b0;
            rd_entry_reg  <= '0;
            best_val_reg  <= '0;
            best_idx_reg  <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            pipe_v_reg    <= pipe_v_next;
            pipe_addr_reg <= pipe_addr_next;
            gram_reg      <= gram_next;
            rd_ok_reg     <= rd_ok_next;
            rd_entry_reg  <= rd_entry_next;
            best_val_reg  <= best_val_next;
            best_idx_reg  <= best_idx_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    // Memories with one write port and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (tmpl_we)
        begin
            tmpl_mem_reg[wr_addr] <= head.value;
        end
        if (min_we)
        begin
            min_mem_reg[wr_addr] <= min_wr_data;
        end
        tmpl_rd_reg <= tmpl_mem_reg[rd_addr];
        min_rd_reg  <= min_mem_reg[rd_addr];
    end

    assign clearing = (state_reg == ST_CLEAR);
    assign m_valid  = res_valid_reg;
    assign m_result = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/min_hamming_distance_tracker_unit.sv @@
// Top level of the minimum Hamming distance tracker: register port, front end,
// request queue and back end. Depends on mhdt_pkg, mhdt_front, mhdt_queue
// and mhdt_back.
`default_nettype none

// The unit keeps ENTRIES template words of SYMBOLS two-bit symbols with a
// running minimum distance beside each. Requests arrive on the slave stream
// with the command in tuser; read and summary requests return one result on
// the master stream, load and scan return none. After reset the distance
// store is cleared to SYMBOLS+1 one entry per cycle, so no request is taken
// until the clearing pass is done. A scan or a summary walks the distance
// memory one entry per cycle for n entries, where n is the clamped active
// entry count, through its single registered read port. Requests queue up
// to four deep while the back end works.
module min_hamming_distance_tracker_unit
    import mhdt_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int SYMBOLS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Register port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    // Request stream.
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: value [63:0], entry [69:64], zero padding [71:70].
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: command [1:0].
    input  wire logic [CMD_W-1:0]     s_axis_tuser,
    // Result stream.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // tdata: distance [5:0], best_entry [11:6], far_enough [12], zero padding [15:13].
    output logic      [M_TDATA_W-1:0] m_axis_tdata
);

    logic [ACTIVE_W-1:0] active_reg, active_next;
    logic [THR_W-1:0]    thresh_reg, thresh_next;
    logic                cfg_wr;
    cfg_t                cfg;

    logic                clearing;
    logic                q_push;
    logic                q_pop;
    cmd_item_t           q_in;
    cmd_item_t           q_head;
    queue_status_t       q_status;
    result_t             result;

    // Register writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        active_next = active_reg;
        thresh_next = thresh_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_ACTIVE: active_next = pwdata[ACTIVE_W-1:0];
                REG_THRESH: thresh_next = pwdata[THR_W-1:0];
                default:    active_next = active_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else
        begin
            active_reg <= active_next;
            thresh_reg <= thresh_next;
        end
    end

    // Register read back.
    always_comb
    begin
        case (paddr[2])
            REG_ACTIVE: prdata = {{(32 - ACTIVE_W){1'b0}}, active_reg};
            REG_THRESH: prdata = {{(32 - THR_W){1'b0}}, thresh_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg.active_entries = active_reg;
    assign cfg.far_threshold  = thresh_reg;

    mhdt_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .clearing      (clearing),
        .q_status      (q_status),
        .push          (q_push),
        .item          (q_in)
    );

    mhdt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .item_in (q_in),
        .pop     (q_pop),
        .head    (q_head),
        .status  (q_status)
    );

    mhdt_back #(
        .ENTRIES (ENTRIES),
        .SYMBOLS (SYMBOLS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_status (q_status),
        .head     (q_head),
        .pop      (q_pop),
        .clearing (clearing),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (result)
    );

    // Pack the result fields from the lowest bit up.
    assign m_axis_tdata = {
        {(M_TDATA_W - DIST_W - ENTRY_W - 1){1'b0}},
        result.far_enough,
        result.best_entry,
        result.distance
    };

`ifndef SYNTH
    // No request may enter while the distance store is being cleared.
    a_no_accept_in_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> !s_axis_tready
    ) else $error("request accepted during the clearing pass");

    // The front end never pushes into a full queue.
    a_queue_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_status.full |-> !q_push
    ) else $error("request queue overflow");

    // The back end only pops a queue that holds a request.
    a_queue_no_underflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty
    ) else $error("request queue underflow");
`endif

endmodule

`default_nettype wire
